FILE: hdl/first_fit_heap_allocator_assert.svh
// Assertion macros used by the allocator controller (ffha_ctrl).
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
`define FFHA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ffha assertion failed");
`define FFHA_NEVER(lbl, clk, rst, cond) \
  `FFHA_ASSERT(lbl, clk, rst, !(cond))
`else
`define FFHA_ASSERT(lbl, clk, rst, prop)
`define FFHA_NEVER(lbl, clk, rst, cond)
`endif

`endif

FILE: hdl/ffha_pkg.sv
package ffha_pkg;

  localparam int HEAP_BYTES      = 65536;
  localparam int HEADER_BYTES    = 32;
  localparam int ALIGN_BYTES     = 16;
  localparam int MIN_SPLIT_BYTES = 16;
  localparam int MAX_BLOCKS      = 2048;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_DONE     = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] hdr;
    logic [15:0] size;
    logic        free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t     status;
    logic [15:0] granted;
    logic [15:0] copy;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  function automatic logic [16:0] round_up(input logic [15:0] n);
    logic [16:0] t;
    t = {1'b0, n} + 17'(ALIGN_BYTES - 1);
    return 17'((t / ALIGN_BYTES) * ALIGN_BYTES);
  endfunction

endpackage

FILE: hdl/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ffha_ctrl.sv
`include "first_fit_heap_allocator_assert.svh"

module ffha_ctrl import ffha_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       operation,
  input  logic [15:0]      request_bytes,
  input  logic [15:0]      payload_offset,
  input  logic             offset_present,
  output logic             idle,
  output logic             done,
  output res_t             res,
  input  logic             take,
  output ram_wr_t          wr,
  output logic [IDX_W-1:0] raddr,
  input  entry_t           rdata
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_FIND_RD, S_FIND_CMP, S_FIT_RD, S_FIT_CMP, S_ALLOC0,
    S_ALLOC_WR0, S_ALLOC_WR1, S_MV_RD, S_MV_WR, S_FREE0, S_NB_RD, S_NB_CMP,
    S_PB0, S_PB_RD, S_PB_CMP, S_MERGE, S_FREE_FIN, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_ALLOC, PH_FREE, PH_RE_FIND, PH_RE_ALLOC, PH_RE_FREE
  } phase_t;

  localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);

  state_t           state;
  phase_t           phase;
  logic [15:0]      req;
  logic [15:0]      off;
  logic [16:0]      want;
  logic [15:0]      old_size;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] k;
  entry_t           cur;
  entry_t           prev;
  logic             nbf;
  logic [15:0]      nb_size;
  logic             pbf;
  logic             split;
  logic [IDX_W-1:0] mv_src;
  logic [IDX_W-1:0] mv_dst;
  logic [CNT_W-1:0] mv_left;
  logic             mv_alloc;

  logic             used_hit;
  logic             fit_hit;
  logic             can_split;
  logic [16:0]      merge_sum;
  logic [16:0]      merge_total;
  logic [IDX_W-1:0] merge_base;
  logic [1:0]       merge_r;
  logic [CNT_W-1:0] merge_left;
  logic [CNT_W-1:0] ins_left;
  entry_t           split_entry;
  logic [16:0]      split_hdr;
  logic [16:0]      split_size;

  always_comb begin
    used_hit  = !rdata.free && (({1'b0, rdata.hdr} + HDR17) == {1'b0, off});
    fit_hit   = rdata.free && ({1'b0, rdata.size} >= want);
    can_split = (cnt < CNT_W'(MAX_BLOCKS)) &&
                ({2'b0, cur.size} >= ({1'b0, want} + 18'(HEADER_BYTES + MIN_SPLIT_BYTES)));
    ins_left  = cnt - CNT_W'(k) - CNT_W'(1);

    merge_sum   = {1'b0, cur.size} + (nbf ? (HDR17 + {1'b0, nb_size}) : 17'd0);
    merge_total = pbf ? ({1'b0, prev.size} + HDR17 + merge_sum) : merge_sum;
    merge_base  = pbf ? (k - IDX_W'(1)) : k;
    merge_r     = {1'b0, nbf} + {1'b0, pbf};
    merge_left  = cnt - CNT_W'(1) - CNT_W'(merge_r) - CNT_W'(merge_base);

    split_hdr   = {1'b0, cur.hdr} + HDR17 + want;
    split_size  = {1'b0, cur.size} - want - HDR17;
    split_entry = '{hdr: split_hdr[15:0], size: split_size[15:0], free: 1'b1};
  end

  // read address follows the state
  always_comb begin
    unique case (state)
      S_MV_RD: raddr = mv_src;
      S_NB_RD: raddr = k + IDX_W'(1);
      S_PB_RD: raddr = k - IDX_W'(1);
      default: raddr = idx[IDX_W-1:0];
    endcase
  end

  always_comb begin
    wr = '{we: 1'b0, addr: '0, data: '0};
    unique case (state)
      S_INIT: begin
        wr = '{we: 1'b1, addr: '0,
               data: '{hdr: 16'd0, size: 16'(HEAP_BYTES - HEADER_BYTES), free: 1'b1}};
      end
      S_MV_WR: wr = '{we: 1'b1, addr: mv_dst, data: rdata};
      S_MERGE: begin
        wr = '{we: 1'b1, addr: merge_base,
               data: '{hdr: pbf ? prev.hdr : cur.hdr, size: merge_total[15:0],
                       free: 1'b1}};
      end
      S_ALLOC_WR0: wr = '{we: 1'b1, addr: k + IDX_W'(1), data: split_entry};
      S_ALLOC_WR1: begin
        wr = '{we: 1'b1, addr: k,
               data: '{hdr: cur.hdr, size: split ? want[15:0] : cur.size, free: 1'b0}};
      end
      default: wr = '{we: 1'b0, addr: '0, data: '0};
    endcase
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      phase <= PH_ALLOC;
      cnt   <= CNT_W'(1);
    end else begin
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            req  <= request_bytes;
            off  <= payload_offset;
            want <= round_up(request_bytes);
            idx  <= '0;
            res  <= '{status: ST_DONE, granted: 16'd0, copy: 16'd0};
            priority if (operation == OP_ALLOC ||
                         (operation == OP_REALLOC && !offset_present)) begin
              phase <= PH_ALLOC;
              state <= (request_bytes == 16'd0) ? S_DONE : S_FIT_RD;
            end else if (operation == OP_FREE) begin
              phase <= PH_FREE;
              state <= offset_present ? S_FIND_RD : S_DONE;
            end else if (operation == OP_REALLOC) begin
              phase <= (request_bytes == 16'd0) ? PH_FREE : PH_RE_FIND;
              state <= S_FIND_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FIND_RD: begin
          if (idx == cnt) begin
            if (phase != PH_RE_FREE) begin
              res.status <= ST_UNKNOWN;
            end
            state <= S_DONE;
          end else begin
            state <= S_FIND_CMP;
          end
        end
        S_FIND_CMP: begin
          if (used_hit) begin
            cur <= rdata;
            k   <= idx[IDX_W-1:0];
            if (phase == PH_RE_FIND) begin
              old_size <= rdata.size;
              phase    <= PH_RE_ALLOC;
              idx      <= '0;
              state    <= S_FIT_RD;
            end else begin
              state <= S_FREE0;
            end
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_FIND_RD;
          end
        end
        S_FIT_RD: begin
          if (idx == cnt) begin
            res.status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            state <= S_FIT_CMP;
          end
        end
        S_FIT_CMP: begin
          if (fit_hit) begin
            cur   <= rdata;
            k     <= idx[IDX_W-1:0];
            state <= S_ALLOC0;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_FIT_RD;
          end
        end
        S_ALLOC0: begin
          split <= can_split;
          if (can_split) begin
            cnt      <= cnt + CNT_W'(1);
            mv_left  <= ins_left;
            mv_src   <= IDX_W'(cnt - CNT_W'(1));
            mv_dst   <= cnt[IDX_W-1:0];
            mv_alloc <= 1'b1;
            state    <= (ins_left == '0) ? S_ALLOC_WR0 : S_MV_RD;
          end else begin
            state <= S_ALLOC_WR1;
          end
        end
        S_ALLOC_WR0: state <= S_ALLOC_WR1;
        S_ALLOC_WR1: begin
          res.status  <= ST_GRANTED;
          res.granted <= 16'({1'b0, cur.hdr} + HDR17);
          if (phase == PH_RE_ALLOC) begin
            res.copy <= (req < old_size) ? req : old_size;
            phase    <= PH_RE_FREE;
            idx      <= '0;
            state    <= S_FIND_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_MV_RD: state <= S_MV_WR;
        S_MV_WR: begin
          mv_left <= mv_left - CNT_W'(1);
          if (mv_alloc) begin
            mv_src <= mv_src - IDX_W'(1);
            mv_dst <= mv_dst - IDX_W'(1);
          end else begin
            mv_src <= mv_src + IDX_W'(1);
            mv_dst <= mv_dst + IDX_W'(1);
          end
          if (mv_left == CNT_W'(1)) begin
            state <= mv_alloc ? S_ALLOC_WR0 : S_FREE_FIN;
          end else begin
            state <= S_MV_RD;
          end
        end
        S_FREE0: begin
          if ((CNT_W'(k) + CNT_W'(1)) < cnt) begin
            state <= S_NB_RD;
          end else begin
            nbf   <= 1'b0;
            state <= S_PB0;
          end
        end
        S_NB_RD: state <= S_NB_CMP;
        S_NB_CMP: begin
          nbf     <= rdata.free;
          nb_size <= rdata.size;
          state   <= S_PB0;
        end
        S_PB0: begin
          if (k != '0) begin
            state <= S_PB_RD;
          end else begin
            pbf   <= 1'b0;
            state <= S_MERGE;
          end
        end
        S_PB_RD: state <= S_PB_CMP;
        S_PB_CMP: begin
          pbf   <= rdata.free;
          prev  <= rdata;
          state <= S_MERGE;
        end
        S_MERGE: begin
          cnt      <= cnt - CNT_W'(merge_r);
          mv_left  <= merge_left;
          mv_src   <= merge_base + IDX_W'(1) + IDX_W'(merge_r);
          mv_dst   <= merge_base + IDX_W'(1);
          mv_alloc <= 1'b0;
          state    <= (merge_left == '0) ? S_FREE_FIN : S_MV_RD;
        end
        S_FREE_FIN: begin
          if (phase != PH_RE_FREE) begin
            res.status <= ST_DONE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFHA_ASSERT(a_start_idle, clk, rst, start |-> state == S_IDLE)
  `FFHA_NEVER(a_cnt_range, clk, rst, (cnt == '0) || (cnt > CNT_W'(MAX_BLOCKS)))
  `FFHA_ASSERT(a_no_write_idle, clk, rst, (state == S_IDLE) |-> !wr.we)
  `FFHA_ASSERT(a_done_hold, clk, rst, (state == S_DONE) && !take |=> state == S_DONE)

endmodule

FILE: hdl/first_fit_heap_allocator.sv
// Walk: each request walks the block table entry by entry, and a
//   split or merge moves the entries behind it one by one; a reallocate
//   walks the table for the old block, for a fit, and again to free it.
// Throughput: one request at a time; the next is taken once the result has
//   moved to the output register. Reset: synchronous rst; after reset the
//   init state writes the single free block covering the whole heap, then the block is ready.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] request_bytes,
  input  logic [15:0] payload_offset,
  input  logic        offset_present,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] granted_offset,
  output logic [15:0] copy_bytes
);

  logic             idle;
  logic             done;
  logic             take;
  logic             start;
  res_t             res;
  ram_wr_t          wr;
  logic [IDX_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t           rdata;

  // accept a request only while the sequencer rests
  assign in_ready = idle;
  assign start    = in_valid & in_ready;

  // move the finished result into the output register when it is empty or being read out
  assign take = done && (!out_valid || out_ready);

  assign rdata = entry_t'(rdata_raw);

  ffha_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .payload_offset (payload_offset),
    .offset_present (offset_present),
    .idle           (idle),
    .done           (done),
    .res            (res),
    .take           (take),
    .wr             (wr),
    .raddr          (raddr),
    .rdata          (rdata)
  );

  // address-ordered block table
  ffha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // output register: hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid      <= 1'b1;
        status         <= res.status;
        granted_offset <= res.granted;
        copy_bytes     <= res.copy;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
